// ----- hdl/ccd_pkg.sv -----
package ccd_pkg;

    localparam int CHANNELS   = 16;
    localparam int N_CTRL     = 11;
    localparam int N_SW       = 6;
    localparam int MAP_W      = 5;
    localparam int CH_W       = 4;
    localparam int RAW_W      = 11;
    localparam int LVL_W      = 11;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = N_CTRL * MAP_W;
    localparam int INV_W      = 2;

    typedef logic signed [LVL_W-1:0] t_level;
    typedef logic [MODE_W-1:0]       t_mode;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_CHANNEL_MAP = 2'd0;
    localparam t_cfg_idx REG_INVERT      = 2'd1;
    localparam t_cfg_idx REG_ON_ABOVE    = 2'd2;
    localparam t_cfg_idx REG_OFF_BELOW   = 2'd3;

    // control order within the channel map
    localparam int CTRL_STEER    = 0;
    localparam int CTRL_THROTTLE = 1;
    localparam int CTRL_PAN      = 2;
    localparam int CTRL_TILT     = 3;
    localparam int CTRL_ARM      = 4;
    localparam int CTRL_DRS      = 5;
    localparam int CTRL_BOOST    = 6;
    localparam int CTRL_OVERTAKE = 7;
    localparam int CTRL_MODE     = 8;
    localparam int CTRL_GEAR_UP  = 9;
    localparam int CTRL_GEAR_DN  = 10;

    // switch bits
    localparam int SW_ARM      = 0;
    localparam int SW_DRS      = 1;
    localparam int SW_BOOST    = 2;
    localparam int SW_OVERTAKE = 3;
    localparam int SW_GEAR_UP  = 4;
    localparam int SW_GEAR_DN  = 5;

    localparam int SW_CTRL [N_SW] = '{CTRL_ARM, CTRL_DRS, CTRL_BOOST, CTRL_OVERTAKE,
                                      CTRL_GEAR_UP, CTRL_GEAR_DN};

    localparam t_mode MODE_LOW  = 2'd0;
    localparam t_mode MODE_MID  = 2'd1;
    localparam t_mode MODE_HIGH = 2'd2;

    localparam t_level MODE_LOW_LIM  = -11'sd333;
    localparam t_level MODE_HIGH_LIM = 11'sd333;

    // scaling: centre 992, spans of 819 (upper) and 820 (lower) raw counts per 1000
    localparam int RAW_CENTRE  = 992;
    localparam int FULL_SCALE  = 1000;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_UPPER =
        RECIP_W'((FULL_SCALE * (64'd1 << RECIP_SHIFT) + 818) / 819);
    localparam logic [RECIP_W-1:0] RECIP_LOWER =
        RECIP_W'((FULL_SCALE * (64'd1 << RECIP_SHIFT) + 819) / 820);

    localparam logic [CFG_DATA_W-1:0] MAP_RESET     = '1;
    localparam t_level                ON_RESET      = 11'sd500;
    localparam t_level                OFF_RESET     = -11'sd500;

endpackage

// ----- hdl/ccd_intf.sv -----
interface ccd_sample_if;
    import ccd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel_number;
    logic [RAW_W-1:0]    raw_value;
    logic                frame_end;

    modport source (output valid, channel_number, raw_value, frame_end, input ready);
    modport sink   (input valid, channel_number, raw_value, frame_end, output ready);
endinterface

interface ccd_result_if;
    import ccd_pkg::*;

    logic   valid;
    logic   ready;
    t_level steering;
    t_level throttle;
    t_level pan;
    t_level tilt;
    logic   arm_on;
    logic   drs_on;
    logic   boost_on;
    logic   overtake_on;
    t_mode  drive_mode;
    logic   gear_up_pulse;
    logic   gear_down_pulse;

    modport source (output valid, steering, throttle, pan, tilt, arm_on, drs_on, boost_on,
                    overtake_on, drive_mode, gear_up_pulse, gear_down_pulse, input ready);
    modport sink   (input valid, steering, throttle, pan, tilt, arm_on, drs_on, boost_on,
                    overtake_on, drive_mode, gear_up_pulse, gear_down_pulse, output ready);
endinterface

interface ccd_cfg_if;
    import ccd_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/rc_channel_control_decoder_unit.sv -----
// channel    | dir | contents
// i_sample   | in  | channel_number, raw_value, frame_end
// o_result   | out | four axes, four switches, drive_mode, two gear pulses
// i_cfg      | in  | register index, write data (always ready)
//
// One sample per cycle unless a stalled result backs up the pipe. Stage one scales the
// raw value (one 11x21 multiply), stage two captures levels and, on frame end, loads
// the result register, which an accepted frame-end request reaches through stages one and two.
// Synchronous active-low reset: controls unmapped, no levels captured, switches off.
// A stalled result holds the next frame-end request in stage two; requests behind it back up.
module rc_channel_control_decoder_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ccd_sample_if.sink      i_sample,
    ccd_result_if.source    o_result,
    ccd_cfg_if.sink         i_cfg
);
    import ccd_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] r_channel_map;
    logic [INV_W-1:0]      r_invert;
    t_level                r_on_above;
    t_level                r_off_below;

    // stage A: accepted request
    logic                  r_a_valid;
    logic [CH_W-1:0]       r_a_ch;
    logic [RAW_W-1:0]      r_a_raw;
    logic                  r_a_fe;

    // stage B: scaled level
    logic                  r_b_valid;
    logic [CH_W-1:0]       r_b_ch;
    t_level                r_b_lvl;
    logic                  r_b_fe;

    // control state
    t_level                r_cap [N_CTRL];
    logic [N_CTRL-1:0]     r_cap_valid;
    logic [N_SW-1:0]       r_sw;
    logic                  r_first;

    // result register
    logic                  r_out_valid;
    t_level                r_steer, r_throttle, r_pan, r_tilt;
    logic [SW_OVERTAKE:0]  r_out_sw;
    t_mode                 r_mode;
    logic                  r_up_pulse, r_dn_pulse;

    logic out_free, b_fire, b_en, a_fire, a_en;

    assign out_free = !r_out_valid || o_result.ready;
    assign b_fire   = r_b_valid && (!r_b_fe || out_free);
    assign b_en     = !r_b_valid || b_fire;
    assign a_fire   = r_a_valid && b_en;
    assign a_en     = !r_a_valid || a_fire;

    assign i_sample.ready = a_en;
    assign i_cfg.ready    = 1'b1;

    // ---------------- scaling ----------------
    logic signed [RAW_W:0] centred;
    logic                  neg;
    logic [RAW_W-1:0]      mag_in;
    logic [31:0]           prod;
    logic [31-RECIP_SHIFT:0] quot;
    logic [LVL_W-1:0]      mag;
    t_level                a_lvl;

    always_comb begin
        centred = $signed({1'b0, r_a_raw}) - (RAW_W+1)'(RAW_CENTRE);
        neg     = centred[RAW_W];
        mag_in  = neg ? RAW_W'(-centred) : RAW_W'(centred);
        prod    = 32'(mag_in) * 32'(neg ? RECIP_LOWER : RECIP_UPPER);
        quot    = prod[31:RECIP_SHIFT];
        mag     = (quot > (32-RECIP_SHIFT)'(FULL_SCALE)) ? LVL_W'(FULL_SCALE) : LVL_W'(quot);
        a_lvl   = neg ? t_level'(-$signed(mag)) : t_level'(mag);
    end

    // ---------------- capture and decode ----------------
    logic [N_CTRL-1:0] hit, map_ok, cap_v, pres;
    t_level            cap_lvl [N_CTRL];
    t_level            use_lvl [N_CTRL];
    logic [N_SW-1:0]   n_sw;
    logic              ch_ok;
    t_level            sv;
    t_mode             n_mode;
    t_level            n_steer, n_throttle;

    always_comb begin
        ch_ok = {1'b0, r_b_ch} < (CH_W+1)'(CHANNELS);
        for (int k = 0; k < N_CTRL; k++) begin
            map_ok[k]  = r_channel_map[MAP_W*k +: MAP_W] < MAP_W'(CHANNELS);
            hit[k]     = ch_ok && (r_channel_map[MAP_W*k +: MAP_W] == MAP_W'(r_b_ch));
            cap_lvl[k] = hit[k] ? r_b_lvl : r_cap[k];
            cap_v[k]   = r_cap_valid[k] || hit[k];
            pres[k]    = map_ok[k] && cap_v[k];
            use_lvl[k] = pres[k] ? cap_lvl[k] : '0;
        end

        for (int s = 0; s < N_SW; s++) begin
            sv = use_lvl[SW_CTRL[s]];
            if (!pres[SW_CTRL[s]]) begin
                n_sw[s] = 1'b0;
            end else if (!r_first || sv > r_on_above) begin
                n_sw[s] = sv > r_on_above;
            end else if (sv < r_off_below) begin
                n_sw[s] = 1'b0;
            end else begin
                n_sw[s] = r_sw[s];
            end
        end

        if (!pres[CTRL_MODE]) begin
            n_mode = MODE_MID;
        end else if (use_lvl[CTRL_MODE] < MODE_LOW_LIM) begin
            n_mode = MODE_LOW;
        end else if (use_lvl[CTRL_MODE] > MODE_HIGH_LIM) begin
            n_mode = MODE_HIGH;
        end else begin
            n_mode = MODE_MID;
        end

        n_steer    = r_invert[0] ? -use_lvl[CTRL_STEER] : use_lvl[CTRL_STEER];
        n_throttle = r_invert[1] ? -use_lvl[CTRL_THROTTLE] : use_lvl[CTRL_THROTTLE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_map <= MAP_RESET;
            r_invert      <= '0;
            r_on_above    <= ON_RESET;
            r_off_below   <= OFF_RESET;
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
            r_cap_valid   <= '0;
            r_sw          <= '0;
            r_first       <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < N_CTRL; k++) begin
                r_cap[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_CHANNEL_MAP: r_channel_map <= i_cfg.data;
                    REG_INVERT:      r_invert      <= i_cfg.data[INV_W-1:0];
                    REG_ON_ABOVE:    r_on_above    <= t_level'(i_cfg.data[LVL_W-1:0]);
                    REG_OFF_BELOW:   r_off_below   <= t_level'(i_cfg.data[LVL_W-1:0]);
                    default: ;
                endcase
            end

            if (a_en) begin
                r_a_valid <= i_sample.valid;
            end
            if (b_en) begin
                r_b_valid <= a_fire;
            end

            if (b_fire) begin
                if (r_b_fe) begin
                    for (int k = 0; k < N_CTRL; k++) begin
                        r_cap[k] <= use_lvl[k];
                    end
                    r_cap_valid <= '0;
                    r_sw        <= n_sw;
                    r_first     <= 1'b1;
                end else begin
                    for (int k = 0; k < N_CTRL; k++) begin
                        r_cap[k] <= cap_lvl[k];
                    end
                    r_cap_valid <= cap_v;
                end
            end

            if (b_fire && r_b_fe) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_a_ch  <= i_sample.channel_number;
            r_a_raw <= i_sample.raw_value;
            r_a_fe  <= i_sample.frame_end;
        end
        if (b_en) begin
            r_b_ch  <= r_a_ch;
            r_b_lvl <= a_lvl;
            r_b_fe  <= r_a_fe;
        end
        if (b_fire && r_b_fe) begin
            r_steer    <= n_steer;
            r_throttle <= n_throttle;
            r_pan      <= use_lvl[CTRL_PAN];
            r_tilt     <= use_lvl[CTRL_TILT];
            r_out_sw   <= n_sw[SW_OVERTAKE:0];
            r_mode     <= n_mode;
            r_up_pulse <= r_first && n_sw[SW_GEAR_UP] && !r_sw[SW_GEAR_UP];
            r_dn_pulse <= r_first && n_sw[SW_GEAR_DN] && !r_sw[SW_GEAR_DN];
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.steering        = r_steer;
    assign o_result.throttle        = r_throttle;
    assign o_result.pan             = r_pan;
    assign o_result.tilt            = r_tilt;
    assign o_result.arm_on          = r_out_sw[SW_ARM];
    assign o_result.drs_on          = r_out_sw[SW_DRS];
    assign o_result.boost_on        = r_out_sw[SW_BOOST];
    assign o_result.overtake_on     = r_out_sw[SW_OVERTAKE];
    assign o_result.drive_mode      = r_mode;
    assign o_result.gear_up_pulse   = r_up_pulse;
    assign o_result.gear_down_pulse = r_dn_pulse;

    // frame end empties the capture set
    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && r_b_fe |=> r_cap_valid == '0)
        else $error("capture set not cleared after frame end");

    // no gear pulse on the first frame
    a_first_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && r_b_fe && !r_first |=> !r_up_pulse && !r_dn_pulse)
        else $error("gear pulse on first frame");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready && b_fire |-> !r_b_fe)
        else $error("result overwritten while stalled");

    // scaled level stays in range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b_lvl <= 11'sd1000 && r_b_lvl >= -11'sd1000)
        else $error("scaled level out of range");

    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_mode == MODE_LOW || r_mode == MODE_MID || r_mode == MODE_HIGH)
        else $error("bad drive mode code");

endmodule

// ----- sim/tb_rc_channel_control_decoder_unit.sv -----
`timescale 1ns / 100ps

module tb_rc_channel_control_decoder_unit;
    import ccd_pkg::*;

    typedef struct {
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        logic             fe;
    } t_sample;

    typedef struct {
        t_level steering;
        t_level throttle;
        t_level pan;
        t_level tilt;
        logic   arm;
        logic   drs;
        logic   boost;
        logic   overtake;
        t_mode  mode;
        logic   gear_up;
        logic   gear_dn;
    } t_controls;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ccd_sample_if smp_if ();
    ccd_result_if res_if ();
    ccd_cfg_if    cfg_if ();

    rc_channel_control_decoder_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_sample   sample_q [$];
    t_controls frame_q [$];
    int        n_errors     = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    int        hold_left    = 0;
    bit        hold_req     = 1'b0;
    bit        hold_done    = 1'b0;

    // decoder image: registers and state
    logic [CFG_DATA_W-1:0] map_r     = '1;
    logic [INV_W-1:0]      inv_r     = '0;
    int                    on_above  = 500;
    int                    off_below = -500;
    int                    lvl [N_CTRL] = '{default: 0};
    logic [N_CTRL-1:0]     got       = '0;
    logic [N_SW-1:0]       sw        = '0;
    bit                    seeded    = 1'b0;

    function automatic int norm_level(logic [RAW_W-1:0] raw);
        int c;
        int n;
        c = int'(raw) - 992;
        if (c >= 0) begin
            n = (c * 1000) / 819;
        end else begin
            n = (c * 1000) / 820;
        end
        if (n > 1000) n = 1000;
        if (n < -1000) n = -1000;
        return n;
    endfunction

    function automatic bit live(int k);
        return (map_r[MAP_W*k +: MAP_W] < CHANNELS) && got[k];
    endfunction

    function automatic bit update_switch(int k, int b);
        bit st;
        st = sw[b];
        if (!live(k)) begin
            st = 1'b0;
        end else if (!seeded) begin
            st = lvl[k] > on_above;
        end else if (lvl[k] > on_above) begin
            st = 1'b1;
        end else if (lvl[k] < off_below) begin
            st = 1'b0;
        end
        sw[b] = st;
        return st;
    endfunction

    function automatic void absorb_sample(t_sample s);
        t_controls e;
        int        lv;
        bit        up_was;
        bit        dn_was;
        bit        up_now;
        bit        dn_now;
        lv = norm_level(s.raw);
        for (int k = 0; k < N_CTRL; k++) begin
            if (map_r[MAP_W*k +: MAP_W] == {1'b0, s.ch}) begin
                lvl[k] = lv;
                got[k] = 1'b1;
            end
        end
        if (!s.fe) return;
        for (int k = 0; k < N_CTRL; k++) begin
            if (!live(k)) lvl[k] = 0;
        end
        e.steering = t_level'(inv_r[0] ? -lvl[CTRL_STEER] : lvl[CTRL_STEER]);
        e.throttle = t_level'(inv_r[1] ? -lvl[CTRL_THROTTLE] : lvl[CTRL_THROTTLE]);
        e.pan      = t_level'(lvl[CTRL_PAN]);
        e.tilt     = t_level'(lvl[CTRL_TILT]);
        e.arm      = update_switch(CTRL_ARM, SW_ARM);
        e.drs      = update_switch(CTRL_DRS, SW_DRS);
        e.boost    = update_switch(CTRL_BOOST, SW_BOOST);
        e.overtake = update_switch(CTRL_OVERTAKE, SW_OVERTAKE);
        e.mode     = MODE_MID;
        if (live(CTRL_MODE)) begin
            if (lvl[CTRL_MODE] < -333) begin
                e.mode = MODE_LOW;
            end else if (lvl[CTRL_MODE] > 333) begin
                e.mode = MODE_HIGH;
            end
        end
        up_was    = sw[SW_GEAR_UP];
        dn_was    = sw[SW_GEAR_DN];
        up_now    = update_switch(CTRL_GEAR_UP, SW_GEAR_UP);
        dn_now    = update_switch(CTRL_GEAR_DN, SW_GEAR_DN);
        e.gear_up = seeded && up_now && !up_was;
        e.gear_dn = seeded && dn_now && !dn_was;
        seeded    = 1'b1;
        got       = '0;
        frame_q.push_back(e);
    endfunction

    function automatic void check_field(string nm, int want, int seen);
        if (want != seen) begin
            n_errors++;
            $display("%0t: %s expected %0d got %0d", $time, nm, want, seen);
        end
    endfunction

    // sample driver
    always @(posedge i_clk) begin : drv
        t_sample nxt;
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready) begin
                absorb_sample('{smp_if.channel_number, smp_if.raw_value, smp_if.frame_end});
            end
            if (!smp_if.valid || smp_if.ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = sample_q.pop_front();
                    smp_if.valid          <= 1'b1;
                    smp_if.channel_number <= nxt.ch;
                    smp_if.raw_value      <= nxt.raw;
                    smp_if.frame_end      <= nxt.fe;
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        t_controls want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (frame_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: expected no result, got steering %0d throttle %0d mode %0d",
                             $time, res_if.steering, res_if.throttle, res_if.drive_mode);
                end else begin
                    want = frame_q.pop_front();
                    check_field("steering", want.steering, res_if.steering);
                    check_field("throttle", want.throttle, res_if.throttle);
                    check_field("pan", want.pan, res_if.pan);
                    check_field("tilt", want.tilt, res_if.tilt);
                    check_field("arm_on", want.arm, res_if.arm_on);
                    check_field("drs_on", want.drs, res_if.drs_on);
                    check_field("boost_on", want.boost, res_if.boost_on);
                    check_field("overtake_on", want.overtake, res_if.overtake_on);
                    check_field("drive_mode", want.mode, res_if.drive_mode);
                    check_field("gear_up_pulse", want.gear_up, res_if.gear_up_pulse);
                    check_field("gear_down_pulse", want.gear_dn, res_if.gear_down_pulse);
                end
            end
            res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_CHANNEL_MAP: map_r     = val;
            REG_INVERT:      inv_r     = val[INV_W-1:0];
            REG_ON_ABOVE:    on_above  = int'($signed(val[LVL_W-1:0]));
            REG_OFF_BELOW:   off_below = int'($signed(val[LVL_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || smp_if.valid || frame_q.size() != 0) @(posedge i_clk);
        // trailing non-frame-end requests may still be in the pipe
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void put(int ch, int raw, bit fe);
        t_sample s;
        s.ch  = ch[CH_W-1:0];
        s.raw = raw[RAW_W-1:0];
        s.fe  = fe;
        sample_q.push_back(s);
    endfunction

    function automatic int raw_for_level(int l);
        int r;
        if (l >= 0) begin
            r = 992 + (l * 819) / 1000;
        end else begin
            r = 992 + (l * 820) / 1000;
        end
        r = r + $urandom_range(6) - 3;
        if (r < 0) r = 0;
        if (r > 2047) r = 2047;
        return r;
    endfunction

    function automatic int raw_pick();
        int r;
        case ($urandom_range(9))
            0: r = $urandom_range(171);
            1: r = $urandom_range(2047, 1812);
            2: begin
                case ($urandom_range(4))
                    0: r = 172;
                    1: r = 992;
                    2: r = 1811;
                    3: r = 991;
                    default: r = 993;
                endcase
            end
            3: r = raw_for_level(on_above);
            4: r = raw_for_level(off_below);
            5: r = raw_for_level($urandom_range(1) ? 333 : -333);
            6: r = $urandom_range(2047);
            default: r = $urandom_range(1811, 172);
        endcase
        return r;
    endfunction

    // well-formed frames with random content; some channels unmapped
    function automatic int push_frame();
        int len;
        int k;
        int ch;
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(11, 1);
        for (int i = 0; i < len; i++) begin
            k  = $urandom_range(N_CTRL - 1);
            ch = map_r[MAP_W*k +: MAP_W];
            if (ch >= CHANNELS || $urandom_range(3) == 0) ch = $urandom_range(CHANNELS - 1);
            put(ch, raw_pick(), i == len - 1);
        end
        return len;
    endfunction

    task automatic load_frames(int n_req);
        int n;
        n = 0;
        @(negedge i_clk);
        while (n < n_req) n += push_frame();
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_map();
        logic [CFG_DATA_W-1:0] m;
        for (int k = 0; k < N_CTRL; k++) begin
            if ($urandom_range(4) == 0) begin
                m[MAP_W*k +: MAP_W] = $urandom_range(31, CHANNELS);
            end else begin
                m[MAP_W*k +: MAP_W] = $urandom_range(7);
            end
        end
        return m;
    endfunction

    initial begin : main
        logic [CFG_DATA_W-1:0] m;
        smp_if.valid          = 1'b0;
        smp_if.channel_number = '0;
        smp_if.raw_value      = '0;
        smp_if.frame_end      = 1'b0;
        res_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_CHANNEL_MAP;
        cfg_if.data           = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 37;
        snk_idle_pct = 46;
        m = '1;
        for (int k = 0; k < N_CTRL; k++) m[MAP_W*k +: MAP_W] = k;
        write_reg(REG_CHANNEL_MAP, m);

        @(negedge i_clk);
        // first frame seeds the switches, no gear pulses
        put(0, 0, 0);
        put(1, 2047, 0);
        put(2, 172, 0);
        put(3, 1811, 0);
        put(4, 1811, 0);
        put(5, 992, 0);
        put(6, 1400, 0);
        put(7, 172, 0);
        put(8, 0, 0);
        put(9, 2047, 0);
        put(10, 172, 0);
        put(12, 500, 1);
        // hysteresis, gear-down edge, missing samples read as absent
        put(4, 172, 0);
        put(6, 2047, 0);
        put(8, 992, 0);
        put(9, 1811, 0);
        put(10, 2047, 0);
        put(0, 993, 0);
        put(1, 991, 0);
        put(11, 0, 1);
        // gear up drops out, then returns with a pulse
        put(8, 2047, 1);
        put(9, 2047, 1);
        drain();

        m = random_map();
        write_reg(REG_CHANNEL_MAP, m);
        write_reg(REG_INVERT, 1);
        write_reg(REG_ON_ABOVE, 1000);
        write_reg(REG_OFF_BELOW, -1000);
        load_frames(240);
        drain();

        src_idle_pct = 46;
        snk_idle_pct = 37;
        write_reg(REG_CHANNEL_MAP, '0);
        write_reg(REG_INVERT, 2);
        write_reg(REG_ON_ABOVE, -1000);
        write_reg(REG_OFF_BELOW, 1000);
        load_frames(200);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        m = random_map();
        write_reg(REG_CHANNEL_MAP, m);
        write_reg(REG_INVERT, 3);
        write_reg(REG_ON_ABOVE, $urandom_range(900));
        write_reg(REG_OFF_BELOW, -$urandom_range(900));
        load_frames(170);
        @(posedge i_clk);
        hold_req <= 1'b1;
        drain();

        write_reg(REG_CHANNEL_MAP, '1);
        write_reg(REG_INVERT, 0);
        write_reg(REG_ON_ABOVE, 500);
        write_reg(REG_OFF_BELOW, -500);
        load_frames(30);
        drain();

        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
